// ----- hdl/assert_macros.svh -----
// Assertion macros used by rau_ctrl. Each check samples on the rising edge of clk
// and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RAU_ASSERT_IMP(lbl, ante, cons, msg)

`define RAU_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/rau_pkg.sv -----
package rau_pkg;

    localparam int RAU_WIDTH   = 32;
    localparam int RAU_MAX_EXP = 64;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_NEG    = 4'd4,
        OP_RECIP  = 4'd5,
        OP_REDUCE = 4'd6,
        OP_POW    = 4'd7,
        OP_TO_INT = 4'd8
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_MK_X,
        CMD_MK_Y,
        CMD_MK_R,
        CMD_NEG_X,
        CMD_NEG_Y,
        CMD_RECIP_X,
        CMD_RECIP_Y,
        CMD_RECIP_R,
        CMD_MUL_NN,
        CMD_MUL_DD,
        CMD_MUL_ND,
        CMD_MUL_DN,
        CMD_ADD,
        CMD_COPY_XR,
        CMD_COPY_RY,
        CMD_GCD_INIT,
        CMD_GCD_FIX,
        CMD_DIV_GCD,
        CMD_DIV_RN,
        CMD_DIV_RD,
        CMD_DIV_INT,
        CMD_TAKE_GCD,
        CMD_TAKE_RN,
        CMD_TAKE_RD,
        CMD_TAKE_INT
    } cmd_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DISPATCH,
        S_MK_A,
        S_MK_B,
        S_NEG_B,
        S_RCP_B,
        S_MK_B2,
        S_NEG_A,
        S_RCP_A,
        S_MK_A2,
        S_COPY_XR,
        S_MUL_ND,
        S_MUL_DN,
        S_ADD,
        S_MUL_NN,
        S_MUL_DD,
        S_MK_R,
        S_GCD_INIT,
        S_GCD_TEST,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_GCD_FIX,
        S_DIV_RN,
        S_WAIT_RN,
        S_DIV_RD,
        S_WAIT_RD,
        S_POW_TEST,
        S_PMUL_N,
        S_PMUL_D,
        S_PMK,
        S_PCOPY,
        S_RCP_R,
        S_DIV_INT,
        S_WAIT_INT,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic op_known;
        logic xd_zero;
        logic p_zero;
        logic cnt_zero;
        logic exp_neg;
        logic div_done;
    } dp_status_t;

endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// One request at a time: busy rises at acceptance and stays high through the done cycle.
// Unknown operation codes go straight from dispatch to done.
// pow multiplies by the operand min(|exponent|, MAX_EXPONENT) times and, for a negative
// exponent, then takes the reciprocal; to_int divides once, reduce once per Euclid step.
// A new request is accepted the cycle after done; results cannot be held off.
// rst_n clears the controller and status flags asynchronously; no clearing pass.
module rational_arithmetic_unit #(
    parameter int WIDTH        = rau_pkg::RAU_WIDTH,
    parameter int MAX_EXPONENT = rau_pkg::RAU_MAX_EXP
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         operation,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    input  logic signed [7:0]  exponent,
    output logic               done,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);
    import rau_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    rau_dp #(
        .W       (WIDTH),
        .MAX_EXP (MAX_EXPONENT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .exponent  (exponent),
        .dp_status (dp_status),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

endmodule

// ----- hdl/rau_div.sv -----
module rau_div #(
    parameter int W = rau_pkg::RAU_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/rau_dp.sv -----
module rau_dp #(
    parameter int W       = rau_pkg::RAU_WIDTH,
    parameter int MAX_EXP = rau_pkg::RAU_MAX_EXP
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::cmd_t       cmd,
    input  logic [3:0]          operation,
    input  logic signed [31:0]  a_num,
    input  logic signed [31:0]  a_den,
    input  logic signed [31:0]  b_num,
    input  logic signed [31:0]  b_den,
    input  logic signed [7:0]   exponent,
    output rau_pkg::dp_status_t dp_status,
    output logic signed [31:0]  res_num,
    output logic [30:0]         res_den,
    output logic [1:0]          status
);
    import rau_pkg::*;

    localparam int CW = $clog2(MAX_EXP + 1);
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_VAL = {{(W-1){1'b0}}, 1'b1};

    logic signed [W-1:0] xn_reg, xn_next, xd_reg, xd_next;
    logic signed [W-1:0] yn_reg, yn_next, yd_reg, yd_next;
    logic signed [W-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic signed [W-1:0] tn_reg, tn_next;
    logic [W-1:0]        p_reg, p_next, q_reg, q_next;
    logic [3:0]          op_reg, op_next;
    logic                ov_reg, ov_next, zd_reg, zd_next;
    logic                eneg_reg, eneg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    logic a_num_ok, a_den_ok, b_num_ok, b_den_ok, known, use_b;
    logic signed [8:0]   e_ext;
    logic [8:0]          e_mag;
    logic [CW-1:0]       cnt_sat;

    logic signed [W-1:0] mk_n, mk_d, mk_n_out, mk_d_out;
    logic                mk_neg, mk_ov, mk_zd;
    logic signed [W-1:0] neg_in, neg_out;
    logic                neg_ov;
    logic signed [W-1:0] mul_a, mul_b, mul_res;
    logic signed [2*W-1:0] prod;
    logic                mul_ov;
    logic [W:0]          sum;
    logic                add_ov;
    logic [W-1:0]        abs_xn, abs_xd;
    logic [W-1:0]        dvd, dvs, div_quo, div_rem, neg_quo;
    logic                div_start, div_done;
    logic signed [31:0]  den_ext;

    // An input fits when its bits above the word are copies of the word's sign.
    assign a_num_ok = (&a_num[31:W-1]) | ~(|a_num[31:W-1]);
    assign a_den_ok = (&a_den[31:W-1]) | ~(|a_den[31:W-1]);
    assign b_num_ok = (&b_num[31:W-1]) | ~(|b_num[31:W-1]);
    assign b_den_ok = (&b_den[31:W-1]) | ~(|b_den[31:W-1]);
    assign known    = operation <= OP_TO_INT;
    assign use_b    = operation <= OP_DIV;

    assign e_ext   = 9'(exponent);
    assign e_mag   = e_ext[8] ? 9'(-e_ext) : 9'(e_ext);
    assign cnt_sat = (e_mag > 9'(MAX_EXP)) ? CW'(MAX_EXP) : CW'(e_mag);

    // Sign normalization of one fraction.
    always_comb
    begin
        unique case (cmd)
            CMD_MK_Y:
            begin
                mk_n = yn_reg;
                mk_d = yd_reg;
            end
            CMD_MK_R:
            begin
                mk_n = rn_reg;
                mk_d = rd_reg;
            end
            default:
            begin
                mk_n = xn_reg;
                mk_d = xd_reg;
            end
        endcase
    end

    assign mk_neg   = mk_d[W-1];
    assign mk_n_out = mk_neg ? -mk_n : mk_n;
    assign mk_d_out = mk_neg ? -mk_d : mk_d;
    assign mk_ov    = mk_neg & ((mk_n == MIN_VAL) | (mk_d == MIN_VAL));
    assign mk_zd    = mk_d == '0;

    assign neg_in  = (cmd == CMD_NEG_Y) ? yn_reg : xn_reg;
    assign neg_out = -neg_in;
    assign neg_ov  = neg_in == MIN_VAL;

    always_comb
    begin
        unique case (cmd)
            CMD_MUL_DD:
            begin
                mul_a = xd_reg;
                mul_b = yd_reg;
            end
            CMD_MUL_ND:
            begin
                mul_a = xn_reg;
                mul_b = yd_reg;
            end
            CMD_MUL_DN:
            begin
                mul_a = yn_reg;
                mul_b = xd_reg;
            end
            default:
            begin
                mul_a = xn_reg;
                mul_b = yn_reg;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign mul_res = prod[W-1:0];
    assign mul_ov  = ~((&prod[2*W-1:W-1]) | ~(|prod[2*W-1:W-1]));

    assign sum    = {rn_reg[W-1], rn_reg} + {tn_reg[W-1], tn_reg};
    assign add_ov = sum[W] ^ sum[W-1];

    assign abs_xn = xn_reg[W-1] ? W'(-xn_reg) : W'(xn_reg);
    assign abs_xd = xd_reg[W-1] ? W'(-xd_reg) : W'(xd_reg);

    always_comb
    begin
        div_start = 1'b1;
        unique case (cmd)
            CMD_DIV_GCD:
            begin
                dvd = q_reg;
                dvs = p_reg;
            end
            CMD_DIV_RN:
            begin
                dvd = abs_xn;
                dvs = q_reg;
            end
            CMD_DIV_RD:
            begin
                dvd = abs_xd;
                dvs = q_reg;
            end
            CMD_DIV_INT:
            begin
                dvd = abs_xn;
                dvs = abs_xd;
            end
            default:
            begin
                dvd       = q_reg;
                dvs       = p_reg;
                div_start = 1'b0;
            end
        endcase
    end

    rau_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign neg_quo = -div_quo;

    always_comb
    begin
        xn_next   = xn_reg;
        xd_next   = xd_reg;
        yn_next   = yn_reg;
        yd_next   = yd_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        tn_next   = tn_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        op_next   = op_reg;
        ov_next   = ov_reg;
        zd_next   = zd_reg;
        eneg_next = eneg_reg;
        cnt_next  = cnt_reg;
        unique case (cmd)
            CMD_LOAD:
            begin
                op_next   = operation;
                zd_next   = 1'b0;
                ov_next   = known & (~a_num_ok | ~a_den_ok |
                                     (use_b & (~b_num_ok | ~b_den_ok)));
                xn_next   = W'(a_num);
                xd_next   = W'(a_den);
                yn_next   = use_b ? W'(b_num) : ONE_VAL;
                yd_next   = use_b ? W'(b_den) : ONE_VAL;
                rn_next   = (operation == OP_POW) ? ONE_VAL : '0;
                rd_next   = ONE_VAL;
                eneg_next = exponent[7];
                cnt_next  = cnt_sat;
            end
            CMD_MK_X:
            begin
                xn_next = mk_n_out;
                xd_next = mk_d_out;
                ov_next = ov_reg | mk_ov;
                zd_next = zd_reg | mk_zd;
            end
            CMD_MK_Y:
            begin
                yn_next = mk_n_out;
                yd_next = mk_d_out;
                ov_next = ov_reg | mk_ov;
                zd_next = zd_reg | mk_zd;
            end
            CMD_MK_R:
            begin
                rn_next = mk_n_out;
                rd_next = mk_d_out;
                ov_next = ov_reg | mk_ov;
                zd_next = zd_reg | mk_zd;
            end
            CMD_NEG_X:
            begin
                xn_next = neg_out;
                ov_next = ov_reg | neg_ov;
            end
            CMD_NEG_Y:
            begin
                yn_next = neg_out;
                ov_next = ov_reg | neg_ov;
            end
            CMD_RECIP_X:
            begin
                xn_next = xd_reg;
                xd_next = xn_reg;
            end
            CMD_RECIP_Y:
            begin
                yn_next = yd_reg;
                yd_next = yn_reg;
            end
            CMD_RECIP_R:
            begin
                rn_next = rd_reg;
                rd_next = rn_reg;
            end
            CMD_MUL_NN, CMD_MUL_ND:
            begin
                rn_next = mul_res;
                ov_next = ov_reg | mul_ov;
            end
            CMD_MUL_DD:
            begin
                rd_next = mul_res;
                ov_next = ov_reg | mul_ov;
            end
            CMD_MUL_DN:
            begin
                tn_next = mul_res;
                ov_next = ov_reg | mul_ov;
            end
            CMD_ADD:
            begin
                rn_next = sum[W-1:0];
                ov_next = ov_reg | add_ov;
            end
            CMD_COPY_XR:
            begin
                rn_next = xn_reg;
                rd_next = xd_reg;
            end
            CMD_COPY_RY:
            begin
                yn_next  = rn_reg;
                yd_next  = rd_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            CMD_GCD_INIT:
            begin
                p_next = abs_xn;
                q_next = abs_xd;
            end
            CMD_GCD_FIX:
            begin
                if (q_reg == '0)
                begin
                    q_next = W'(1);
                end
            end
            CMD_TAKE_GCD:
            begin
                q_next = p_reg;
                p_next = div_rem;
            end
            CMD_TAKE_RN:
            begin
                rn_next = xn_reg[W-1] ? neg_quo : div_quo;
            end
            CMD_TAKE_RD:
            begin
                rd_next = xd_reg[W-1] ? neg_quo : div_quo;
            end
            CMD_TAKE_INT:
            begin
                rn_next = (xn_reg[W-1] ^ xd_reg[W-1]) ? neg_quo : div_quo;
                rd_next = ONE_VAL;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= '0;
            ov_reg   <= 1'b0;
            zd_reg   <= 1'b0;
            eneg_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            ov_reg   <= ov_next;
            zd_reg   <= zd_next;
            eneg_reg <= eneg_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xn_reg <= xn_next;
        xd_reg <= xd_next;
        yn_reg <= yn_next;
        yd_reg <= yd_next;
        rn_reg <= rn_next;
        rd_reg <= rd_next;
        tn_reg <= tn_next;
        p_reg  <= p_next;
        q_reg  <= q_next;
    end

    assign dp_status.op       = op_t'(op_reg);
    assign dp_status.op_known = op_reg <= OP_TO_INT;
    assign dp_status.xd_zero  = xd_reg == '0;
    assign dp_status.p_zero   = p_reg == '0;
    assign dp_status.cnt_zero = cnt_reg == '0;
    assign dp_status.exp_neg  = eneg_reg;
    assign dp_status.div_done = div_done;

    assign den_ext = 32'(rd_reg);
    assign res_num = zd_reg ? '0 : 32'(rn_reg);
    assign res_den = zd_reg ? '0 : den_ext[30:0];
    assign status  = zd_reg ? ST_ZERO_DEN : (ov_reg ? ST_OVERFLOW : ST_OK);

endmodule

// ----- hdl/rau_ctrl.sv -----
`include "assert_macros.svh"

module rau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rau_pkg::dp_status_t dp_status,
    output rau_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (start) state_next = S_DISPATCH;
            S_DISPATCH: state_next = dp_status.op_known ? S_MK_A : S_DONE;
            S_MK_A:
            begin
                unique case (dp_status.op)
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_next = S_MK_B;
                    OP_NEG:    state_next = S_NEG_A;
                    OP_RECIP:  state_next = S_RCP_A;
                    OP_REDUCE: state_next = S_GCD_INIT;
                    OP_POW:    state_next = S_POW_TEST;
                    OP_TO_INT: state_next = dp_status.xd_zero ? S_DONE : S_DIV_INT;
                    default:   state_next = S_DONE;
                endcase
            end
            S_MK_B:
            begin
                unique case (dp_status.op)
                    OP_SUB:  state_next = S_NEG_B;
                    OP_MUL:  state_next = S_MUL_NN;
                    OP_DIV:  state_next = S_RCP_B;
                    default: state_next = S_MUL_ND;
                endcase
            end
            S_NEG_B:    state_next = S_MK_B2;
            S_RCP_B:    state_next = S_MK_B2;
            S_MK_B2:    state_next = (dp_status.op == OP_DIV) ? S_MUL_NN : S_MUL_ND;
            S_NEG_A:    state_next = S_MK_A2;
            S_RCP_A:    state_next = S_MK_A2;
            S_MK_A2:    state_next = S_COPY_XR;
            S_COPY_XR:  state_next = S_DONE;
            S_MUL_ND:   state_next = S_MUL_DN;
            S_MUL_DN:   state_next = S_ADD;
            S_ADD:      state_next = S_MUL_DD;
            S_MUL_NN:   state_next = S_MUL_DD;
            S_MUL_DD:   state_next = S_MK_R;
            S_MK_R:     state_next = S_DONE;
            S_GCD_INIT: state_next = S_GCD_TEST;
            S_GCD_TEST: state_next = dp_status.p_zero ? S_GCD_FIX : S_GCD_DIV;
            S_GCD_DIV:  state_next = S_GCD_WAIT;
            S_GCD_WAIT: if (dp_status.div_done) state_next = S_GCD_TEST;
            S_GCD_FIX:  state_next = S_DIV_RN;
            S_DIV_RN:   state_next = S_WAIT_RN;
            S_WAIT_RN:  if (dp_status.div_done) state_next = S_DIV_RD;
            S_DIV_RD:   state_next = S_WAIT_RD;
            S_WAIT_RD:  if (dp_status.div_done) state_next = S_MK_R;
            S_POW_TEST:
            begin
                if (!dp_status.cnt_zero)
                begin
                    state_next = S_PMUL_N;
                end
                else
                begin
                    state_next = dp_status.exp_neg ? S_RCP_R : S_DONE;
                end
            end
            S_PMUL_N:   state_next = S_PMUL_D;
            S_PMUL_D:   state_next = S_PMK;
            S_PMK:      state_next = S_PCOPY;
            S_PCOPY:    state_next = S_POW_TEST;
            S_RCP_R:    state_next = S_MK_R;
            S_DIV_INT:  state_next = S_WAIT_INT;
            S_WAIT_INT: if (dp_status.div_done) state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = CMD_NOP;
        unique case (state_reg)
            S_IDLE:     if (start) cmd = CMD_LOAD;
            S_MK_A:     cmd = CMD_MK_X;
            S_MK_A2:    cmd = CMD_MK_X;
            S_MK_B:     cmd = CMD_MK_Y;
            S_MK_B2:    cmd = CMD_MK_Y;
            S_NEG_B:    cmd = CMD_NEG_Y;
            S_RCP_B:    cmd = CMD_RECIP_Y;
            S_NEG_A:    cmd = CMD_NEG_X;
            S_RCP_A:    cmd = CMD_RECIP_X;
            S_COPY_XR:  cmd = CMD_COPY_XR;
            S_MUL_ND:   cmd = CMD_MUL_ND;
            S_MUL_DN:   cmd = CMD_MUL_DN;
            S_ADD:      cmd = CMD_ADD;
            S_MUL_NN:   cmd = CMD_MUL_NN;
            S_MUL_DD:   cmd = CMD_MUL_DD;
            S_MK_R:     cmd = CMD_MK_R;
            S_GCD_INIT: cmd = CMD_GCD_INIT;
            S_GCD_DIV:  cmd = CMD_DIV_GCD;
            S_GCD_WAIT: if (dp_status.div_done) cmd = CMD_TAKE_GCD;
            S_GCD_FIX:  cmd = CMD_GCD_FIX;
            S_DIV_RN:   cmd = CMD_DIV_RN;
            S_WAIT_RN:  if (dp_status.div_done) cmd = CMD_TAKE_RN;
            S_DIV_RD:   cmd = CMD_DIV_RD;
            S_WAIT_RD:  if (dp_status.div_done) cmd = CMD_TAKE_RD;
            S_PMUL_N:   cmd = CMD_MUL_NN;
            S_PMUL_D:   cmd = CMD_MUL_DD;
            S_PMK:      cmd = CMD_MK_R;
            S_PCOPY:    cmd = CMD_COPY_RY;
            S_RCP_R:    cmd = CMD_RECIP_R;
            S_DIV_INT:  cmd = CMD_DIV_INT;
            S_WAIT_INT: if (dp_status.div_done) cmd = CMD_TAKE_INT;
            default:    cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    `RAU_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `RAU_ASSERT_NXT(a_done_single, done, !done, "result strobe held longer than one cycle")
    `RAU_ASSERT_IMP(a_take_on_done, cmd == CMD_TAKE_GCD || cmd == CMD_TAKE_RN || cmd == CMD_TAKE_RD || cmd == CMD_TAKE_INT, dp_status.div_done, "divider result taken before done")

endmodule

// ----- test/tb.sv -----
module tb;
    import rau_pkg::*;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
        logic signed [7:0]  ex;
    } rat_req_t;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  st;
    } rat_res_t;

    typedef struct {
        longint n;
        longint d;
    } frac_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    logic signed [7:0]  exponent;
    logic               done;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;

    rat_req_t pending_reqs[$];
    rat_res_t expected_results[$];
    logic     took;
    int       gap;
    int       errors;
    int       checked;
    int       op_seen[16];
    int       status_seen[4];

    // Flags raised while one expected result is being computed.
    bit wrapped;
    bit zero_den;

    rational_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .exponent  (exponent),
        .done      (done),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint wrap_word(longint x);
        longint v;
        v = $signed(x[31:0]);
        if (v != x)
            wrapped = 1'b1;
        return v;
    endfunction

    function automatic frac_t make_frac(longint n, longint d);
        frac_t r;
        if (d == 0)
            zero_den = 1'b1;
        else if (d < 0)
        begin
            n = wrap_word(-n);
            d = wrap_word(-d);
        end
        r.n = n;
        r.d = d;
        return r;
    endfunction

    function automatic frac_t frac_mul(frac_t x, frac_t y);
        return make_frac(wrap_word(x.n * y.n), wrap_word(x.d * y.d));
    endfunction

    function automatic frac_t frac_add(frac_t x, frac_t y);
        longint s;
        s = wrap_word(wrap_word(x.n * y.d) + wrap_word(y.n * x.d));
        return make_frac(s, wrap_word(x.d * y.d));
    endfunction

    function automatic frac_t frac_neg(frac_t x);
        return make_frac(wrap_word(-x.n), x.d);
    endfunction

    function automatic frac_t frac_recip(frac_t x);
        return make_frac(x.d, x.n);
    endfunction

    function automatic frac_t frac_reduce(frac_t x);
        longint p;
        longint q;
        longint t;
        p = x.n < 0 ? -x.n : x.n;
        q = x.d < 0 ? -x.d : x.d;
        while (p != 0)
        begin
            t = q % p;
            q = p;
            p = t;
        end
        if (q == 0)
            q = 1;
        return make_frac(x.n / q, x.d / q);
    endfunction

    function automatic frac_t frac_pow(frac_t x, longint e);
        longint mag;
        frac_t  r;
        mag = e < 0 ? -e : e;
        if (mag > RAU_MAX_EXP)
            mag = RAU_MAX_EXP;
        r.n = 1;
        r.d = 1;
        for (longint i = 0; i < mag; i++)
            r = frac_mul(x, r);
        if (e < 0)
            r = frac_recip(r);
        return r;
    endfunction

    function automatic rat_res_t rational_result(rat_req_t q);
        frac_t    a;
        frac_t    b;
        frac_t    r;
        rat_res_t res;
        wrapped  = 1'b0;
        zero_den = 1'b0;
        r.n = 0;
        r.d = 1;
        if (q.op <= OP_TO_INT)
        begin
            a = make_frac(longint'(q.an), longint'(q.ad));
            if (q.op <= OP_DIV)
                b = make_frac(longint'(q.bn), longint'(q.bd));
            case (op_t'(q.op))
                OP_ADD:    r = frac_add(a, b);
                OP_SUB:    r = frac_add(a, frac_neg(b));
                OP_MUL:    r = frac_mul(a, b);
                OP_DIV:    r = frac_mul(a, frac_recip(b));
                OP_NEG:    r = frac_neg(a);
                OP_RECIP:  r = frac_recip(a);
                OP_REDUCE: r = frac_reduce(a);
                OP_POW:    r = frac_pow(a, longint'(q.ex));
                default:
                begin
                    r.n = wrap_word(a.d != 0 ? a.n / a.d : 0);
                    r.d = 1;
                end
            endcase
        end
        if (zero_den)
        begin
            r.n = 0;
            r.d = 0;
            res.st = ST_ZERO_DEN;
        end
        else if (wrapped)
            res.st = ST_OVERFLOW;
        else
            res.st = ST_OK;
        res.num = r.n[31:0];
        res.den = r.d[30:0];
        return res;
    endfunction

    // Driver: one request at a time, holding start until it is taken, with a random gap after each.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start)
            begin
                if (took)
                begin
                    start <= 1'b0;
                    gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 3);
                end
            end
            else if (gap > 0)
                gap <= gap - 1;
            else if (pending_reqs.size() > 0)
            begin
                rat_req_t q;
                q = pending_reqs.pop_front();
                operation <= q.op;
                a_num <= q.an;
                a_den <= q.ad;
                b_num <= q.bn;
                b_den <= q.bd;
                exponent <= q.ex;
                start <= 1'b1;
            end
        end
    end

    // Monitor: check results first, then predict the request taken at this edge.
    always @(posedge clk)
    begin
        rat_req_t q;
        rat_res_t exp_res;
        took <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                checked++;
                status_seen[exp_res.st]++;
                if (res_num !== exp_res.num)
                begin
                    $error("res_num: expected %h, got %h", exp_res.num, res_num);
                    errors++;
                end
                if (res_den !== exp_res.den)
                begin
                    $error("res_den: expected %h, got %h", exp_res.den, res_den);
                    errors++;
                end
                if (status !== exp_res.st)
                begin
                    $error("status: expected %0d, got %0d", exp_res.st, status);
                    errors++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            q.op = operation;
            q.an = a_num;
            q.ad = a_den;
            q.bn = b_num;
            q.bd = b_den;
            q.ex = exponent;
            op_seen[q.op]++;
            expected_results.push_back(rational_result(q));
        end
    end

    task automatic add_req(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, logic [7:0] ex);
        rat_req_t q;
        q.op = op;
        q.an = an;
        q.ad = ad;
        q.bn = bn;
        q.bd = bd;
        q.ex = ex;
        pending_reqs.push_back(q);
    endtask

    function automatic logic [31:0] pick_word(bit allow_zero);
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0, 1, 2: w = $urandom_range(0, 40) - 20;
            3:       w = $urandom;
            4:       w = $urandom_range(0, 3000) - 1500;
            5:       w = 32'sd1 <<< $urandom_range(0, 31);
            6:       w = ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                         + $urandom_range(0, 2) - 1;
            default: w = $urandom_range(0, 65535) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
        if (!allow_zero && w == 0)
            w = 1;
        return w;
    endfunction

    initial
    begin
        logic [3:0] op;
        logic [7:0] ex;
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        a_num = '0;
        a_den = 32'd1;
        b_num = '0;
        b_den = 32'd1;
        exponent = '0;
        took = 1'b0;
        gap = 0;
        errors = 0;
        checked = 0;

        // Every operation, zero denominators, the most negative denominator,
        // saturated and negative powers, unknown codes.
        add_req(OP_ADD, 3, 4, -5, 6, 0);
        add_req(OP_SUB, 32'h7fffffff, 1, 32'h80000000, 1, 0);
        add_req(OP_MUL, 32'h80000000, -1, 32'h7fffffff, 32'h7fffffff, 0);
        add_req(OP_DIV, 7, 3, 0, 5, 0);
        add_req(OP_DIV, 7, 3, 2, 0, 0);
        add_req(OP_NEG, 32'h80000000, 1, 0, 0, 0);
        add_req(OP_RECIP, 0, 5, 0, 0, 0);
        add_req(OP_RECIP, -4, 9, 0, 0, 0);
        add_req(OP_REDUCE, -84, -36, 0, 0, 0);
        add_req(OP_REDUCE, 0, 17, 0, 0, 0);
        add_req(OP_REDUCE, 32'h80000000, 32'h80000000, 0, 0, 0);
        add_req(OP_POW, 2, 3, 0, 0, 8'sd64);
        add_req(OP_POW, -3, 2, 0, 0, -8'sd64);
        add_req(OP_POW, 5, 7, 0, 0, 8'h7f);
        add_req(OP_POW, 1, -1, 0, 0, 8'h80);
        add_req(OP_POW, 0, 1, 0, 0, -8'sd1);
        add_req(OP_POW, 9, 4, 0, 0, 0);
        add_req(OP_TO_INT, -7, 2, 0, 0, 0);
        add_req(OP_TO_INT, 32'h80000000, -1, 0, 0, 0);
        add_req(OP_TO_INT, 5, 0, 0, 0, 0);
        add_req(OP_ADD, 1, 32'h80000000, 1, 1, 0);
        add_req(OP_NEG, 3, 32'h80000000, 0, 0, 0);
        add_req(4'd9, 1, 2, 3, 4, 5);
        add_req(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 8'hff);

        repeat (380)
        begin
            op = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            if ($urandom_range(0, 4) == 0)
                ex = 8'($urandom);
            else
                ex = 8'($urandom_range(0, 16) - 8);
            add_req(op, pick_word(1'b1), pick_word($urandom_range(0, 15) == 0),
                    pick_word(1'b1), pick_word($urandom_range(0, 15) == 0), ex);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        $display("tb: %0d results checked; add %0d sub %0d mul %0d div %0d neg %0d",
                 checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("tb: recip %0d reduce %0d pow %0d to_int %0d; ok %0d zero-den %0d ovf %0d",
                 op_seen[5], op_seen[6], op_seen[7], op_seen[8],
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
